// ----- hw/rtl/rslc_pkg.sv -----
// Shared types and constants for the RGB LED shift frame controller.
// No dependencies; the top-level controller imports this package.
package rslc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_COPY,
        ST_EMIT
    } t_state;

    typedef logic [2:0] t_action;

    localparam t_action ACT_ON     = 3'd0;
    localparam t_action ACT_OFF    = 3'd1;
    localparam t_action ACT_BRIGHT = 3'd2;
    localparam t_action ACT_COLOR  = 3'd3;
    localparam t_action ACT_BURST  = 3'd4;

    localparam logic [7:0] PCT_MAX     = 8'd100;
    localparam logic [7:0] COLOR_MAX   = 8'd3;
    localparam logic [7:0] LEVEL_FULL  = 8'hff;
    localparam logic [5:0] BRIGHT_FULL = 6'h3f;

    // x / 100 for x up to 6300 equals (x * RECIP_100) >> RECIP_SHIFT.
    localparam logic [15:0] RECIP_100   = 16'd41944;
    localparam int          RECIP_SHIFT = 22;

endpackage

// ----- hw/rtl/rslc_bank_mem.sv -----
// Level bank memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as the reset level.
// Has no dependencies; it does not import rslc_pkg.
module rslc_bank_mem #(
    parameter int DEPTH   = 24,
    parameter int WIDTH   = 8,
    parameter int RST_VAL = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_q;
    logic             r_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q  <= r_mem[i_raddr];
        r_qv <= r_valid[i_raddr];
    end

    assign o_rdata = r_qv ? r_q : WIDTH'(RST_VAL);

endmodule

// ----- hw/rtl/rslc_stage_mem.sv -----
// Staging memory for burst bytes, one write and one registered read port.
// No reset; only entries written in the current burst are ever read.
module rslc_stage_mem #(
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- hw/rtl/rgb_led_shift_frame_controller.sv -----
// An update passes decode and then the LED write or the burst copy before its frame;
// then 3*LED_COUNT words leave one per cycle, read through the address shared by both bank memories.
// A staged burst byte or an error goes from decode back to idle; errors give one result the cycle after decode.
// The block takes a new command only while idle, when busy is low.
// No stall from the receiver; reset (synchronous, active low): dots 0, brightness 63, no burst.
// Depends on rslc_pkg, rslc_bank_mem and rslc_stage_mem.
module rgb_led_shift_frame_controller #(
    parameter int LED_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rslc_pkg::t_action  i_action,
    input  logic [7:0]         i_led,
    input  logic [7:0]         i_level,
    input  logic [7:0]         i_color_count,
    input  logic [7:0]         i_color_first,
    input  logic [7:0]         i_color_second,
    input  logic [7:0]         i_color_third,
    input  logic [7:0]         i_first_channel,
    input  logic [7:0]         i_channel_byte,
    input  logic               i_burst_last,
    output logic               o_strobe,
    output logic               o_has_word,
    output logic [7:0]         o_shift_word,
    output logic               o_dot_bank,
    output logic               o_latch_after,
    output logic               o_status
);
    import rslc_pkg::*;

    // Channel 3*led+c holds color c of a LED; both banks share the channel index.
    localparam int NUM_CH = 3 * LED_COUNT;
    localparam int CH_W   = $clog2(NUM_CH);
    localparam int OFS_W  = $clog2(NUM_CH + 1);
    localparam logic [7:0] LED_LIM = 8'(LED_COUNT);
    localparam logic [8:0] CH_LIM  = 9'(NUM_CH);

    t_state r_state, n_state;

    // Captured command transaction.
    t_action    r_action;
    logic [7:0] r_led, r_level, r_color_count;
    logic [7:0] r_c0, r_c1, r_c2;
    logic [7:0] r_first_channel, r_channel_byte;
    logic       r_burst_last;

    // Burst bookkeeping.
    logic [7:0]       r_burst_start;
    logic [OFS_W-1:0] r_burst_offset;
    logic             r_burst_ovf;

    // Three-entry write sequence for LED commands.
    logic [7:0]      r_wdat [3];
    logic [1:0]      r_wi;
    logic [CH_W-1:0] r_base;
    logic            r_bank_dot;

    // Burst copy from staging memory into the dot bank.
    logic [OFS_W-1:0] r_ci, r_cnt;
    logic [CH_W-1:0]  r_cstart, r_cp_addr;
    logic             r_cp_v;

    // Frame emission and result registers.
    logic [CH_W-1:0] r_ch;
    logic            r_word_v, r_word_last, r_err_v;

    // Memory ports.
    logic            dot_we, bri_we, stage_we;
    logic [CH_W-1:0] dot_waddr, bri_waddr, stage_waddr, bank_raddr, stage_raddr;
    logic [7:0]      dot_wdata, stage_wdata, dot_q, stage_q;
    logic [5:0]      bri_wdata, bri_q;

    // Decode of the captured command.
    logic             led_bad, cmd_err;
    logic [13:0]      lvl63;
    logic [29:0]      pct_prod;
    logic [5:0]       bright_v;
    logic [7:0]       start_eff;
    logic [8:0]       burst_pos;
    logic             burst_fits;
    logic             n_ovf;
    logic [OFS_W-1:0] n_offset;
    logic [CH_W-1:0]  wr_addr;

    always_comb begin
        led_bad   = (r_led >= LED_LIM);
        // level * 63 is a shift and a subtract; the divide by 100 is a reciprocal multiply.
        lvl63     = {r_level, 6'b0} - 14'(r_level);
        pct_prod  = 30'(lvl63) * 30'(RECIP_100);
        bright_v  = pct_prod[RECIP_SHIFT +: 6];
        // The first byte of a burst fixes its start channel.
        start_eff = ((r_burst_offset == '0) && !r_burst_ovf) ? r_first_channel : r_burst_start;
        burst_pos = {1'b0, start_eff} + 9'(r_burst_offset);
        burst_fits = !r_burst_ovf && (burst_pos < CH_LIM);
        n_ovf     = r_burst_ovf || !burst_fits;
        n_offset  = burst_fits ? (r_burst_offset + OFS_W'(1)) : r_burst_offset;
        wr_addr   = r_base + CH_W'(r_wi);
        unique case (r_action) inside
            ACT_ON, ACT_OFF: cmd_err = led_bad;
            ACT_BRIGHT:      cmd_err = led_bad || (r_level > PCT_MAX);
            ACT_COLOR:       cmd_err = led_bad || (r_color_count == 8'd0)
                                       || (r_color_count > COLOR_MAX);
            ACT_BURST:       cmd_err = r_burst_last && n_ovf;
            default:         cmd_err = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (cmd_err) begin
                    n_state = ST_IDLE;
                end else if (r_action == ACT_BURST) begin
                    n_state = r_burst_last ? ST_COPY : ST_IDLE;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_wi == 2'd2) begin
                    n_state = ST_EMIT;
                end
            end
            ST_COPY: begin
                // Leave once every byte is read; the last write lands this cycle.
                if (r_ci == r_cnt) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_ch == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        dot_we      = r_cp_v || ((r_state == ST_WRITE) && r_bank_dot);
        dot_waddr   = r_cp_v ? r_cp_addr : wr_addr;
        dot_wdata   = r_cp_v ? stage_q : r_wdat[r_wi];
        bri_we      = (r_state == ST_WRITE) && !r_bank_dot;
        bri_waddr   = wr_addr;
        bri_wdata   = r_wdat[r_wi][5:0];
        bank_raddr  = r_ch;
        stage_we    = (r_state == ST_DECODE) && (r_action == ACT_BURST) && burst_fits;
        stage_waddr = r_burst_offset[CH_W-1:0];
        stage_wdata = r_channel_byte;
        stage_raddr = r_ci[CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_burst_start  <= '0;
            r_burst_offset <= '0;
            r_burst_ovf    <= 1'b0;
            r_cp_v         <= 1'b0;
            r_word_v       <= 1'b0;
            r_err_v        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cp_v   <= (r_state == ST_COPY) && (r_ci != r_cnt);
            r_word_v <= (r_state == ST_EMIT);
            r_err_v  <= (r_state == ST_DECODE) && cmd_err;
            if ((r_state == ST_DECODE) && (r_action == ACT_BURST)) begin
                if (r_burst_last) begin
                    r_burst_start  <= '0;
                    r_burst_offset <= '0;
                    r_burst_ovf    <= 1'b0;
                end else begin
                    r_burst_start  <= start_eff;
                    r_burst_offset <= n_offset;
                    r_burst_ovf    <= n_ovf;
                end
            end
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge i_clk) begin
        r_word_last <= (r_ch == '0);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_action        <= i_action;
                    r_led           <= i_led;
                    r_level         <= i_level;
                    r_color_count   <= i_color_count;
                    r_c0            <= i_color_first;
                    r_c1            <= i_color_second;
                    r_c2            <= i_color_third;
                    r_first_channel <= i_first_channel;
                    r_channel_byte  <= i_channel_byte;
                    r_burst_last    <= i_burst_last;
                end
            end
            ST_DECODE: begin
                r_wi     <= 2'd0;
                r_base   <= CH_W'(9'({r_led, 1'b0}) + 9'(r_led));
                r_ch     <= CH_W'(NUM_CH - 1);
                r_ci     <= '0;
                r_cnt    <= n_offset;
                r_cstart <= start_eff[CH_W-1:0];
                case (r_action)
                    ACT_ON: begin
                        r_bank_dot <= 1'b1;
                        r_wdat[0]  <= LEVEL_FULL;
                        r_wdat[1]  <= LEVEL_FULL;
                        r_wdat[2]  <= LEVEL_FULL;
                    end
                    ACT_OFF: begin
                        r_bank_dot <= 1'b1;
                        r_wdat[0]  <= 8'd0;
                        r_wdat[1]  <= 8'd0;
                        r_wdat[2]  <= 8'd0;
                    end
                    ACT_BRIGHT: begin
                        r_bank_dot <= 1'b0;
                        r_wdat[0]  <= {2'b0, bright_v};
                        r_wdat[1]  <= {2'b0, bright_v};
                        r_wdat[2]  <= {2'b0, bright_v};
                    end
                    ACT_COLOR: begin
                        // Colors that were not given are written as zero.
                        r_bank_dot <= 1'b1;
                        r_wdat[0]  <= r_c0;
                        r_wdat[1]  <= (r_color_count >= 8'd2) ? r_c1 : 8'd0;
                        r_wdat[2]  <= (r_color_count == COLOR_MAX) ? r_c2 : 8'd0;
                    end
                    default: begin
                        r_bank_dot <= 1'b1;
                    end
                endcase
            end
            ST_WRITE: begin
                r_wi <= r_wi + 2'd1;
            end
            ST_COPY: begin
                if (r_ci != r_cnt) begin
                    r_cp_addr <= r_cstart + CH_W'(r_ci);
                    r_ci      <= r_ci + OFS_W'(1);
                end
            end
            ST_EMIT: begin
                r_ch <= r_ch - CH_W'(1);
            end
            default: begin
            end
        endcase
    end

    rslc_bank_mem #(
        .DEPTH   (NUM_CH),
        .WIDTH   (8),
        .RST_VAL (0)
    ) u_dot_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dot_we),
        .i_waddr (dot_waddr),
        .i_wdata (dot_wdata),
        .i_raddr (bank_raddr),
        .o_rdata (dot_q)
    );

    rslc_bank_mem #(
        .DEPTH   (NUM_CH),
        .WIDTH   (6),
        .RST_VAL (63)
    ) u_bri_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (bri_we),
        .i_waddr (bri_waddr),
        .i_wdata (bri_wdata),
        .i_raddr (bank_raddr),
        .o_rdata (bri_q)
    );

    rslc_stage_mem #(
        .DEPTH (NUM_CH)
    ) u_stage_mem (
        .i_clk   (i_clk),
        .i_we    (stage_we),
        .i_waddr (stage_waddr),
        .i_wdata (stage_wdata),
        .i_raddr (stage_raddr),
        .o_rdata (stage_q)
    );

    // A word result appears in the cycle after its bank read; an error result stands alone.
    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_word_v || r_err_v;
    assign o_has_word    = r_word_v;
    assign o_shift_word  = !r_word_v ? 8'd0 :
                           r_bank_dot ? dot_q : {2'b0, bri_q & BRIGHT_FULL};
    assign o_dot_bank    = r_word_v && r_bank_dot;
    assign o_latch_after = r_word_v && r_word_last;
    assign o_status      = r_err_v;

endmodule
